// ===== rtl/sha1mh_pkg.sv =====
// package with the types, constants and round functions of the sha-1 hasher
`timescale 1ns / 1ps
`default_nettype none
package sha1mh_pkg;

	localparam int unsigned ROUNDS = 80;
	localparam int unsigned WORDS  = 5;

	localparam logic [4:0][31:0] H_INIT = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [7:0] PAD_BYTE    = 8'h80;
	localparam logic [5:0] LEN_POS     = 6'd56;
	localparam logic [5:0] LAST_POS    = 6'd63;
	localparam logic [6:0] LAST_ROUND  = 7'd79;
	localparam logic [2:0] LAST_WORD   = 3'd4;
	localparam logic [2:0] LAST_LEN    = 3'd7;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_COMP,
		S_ADD,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		BSEL_IN,
		BSEL_PAD,
		BSEL_ZERO,
		BSEL_LEN
	} byte_sel_t;

	typedef struct packed {
		logic      load_byte;
		byte_sel_t byte_sel;
		logic      count_byte;
		logic [2:0] len_idx;
		logic      round_start;
		logic      round_en;
		logic [6:0] round_idx;
		logic      add_en;
		logic      reinit;
		logic [2:0] out_idx;
	} cmd_t;

	typedef struct packed {
		logic pos_last;
		logic pos_at_len;
	} sts_t;

	function automatic logic [31:0] round_k(input logic [6:0] r);
		logic [31:0] k;
		if (r < 7'd20) begin
			k = 32'h5A827999;
		end else if (r < 7'd40) begin
			k = 32'h6ED9EBA1;
		end else if (r < 7'd60) begin
			k = 32'h8F1BBCDC;
		end else begin
			k = 32'hCA62C1D6;
		end
		return k;
	endfunction

	function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (r < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (r < 7'd40) begin
			f = b ^ c ^ d;
		end else if (r < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/sha1mh_datapath.sv =====
// sha-1 datapath: message window, round registers, chaining words and counters
`timescale 1ns / 1ps
`default_nettype none
module sha1mh_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sha1mh_pkg::cmd_t  cmd,
	input  wire logic [7:0]        message_byte,
	output sha1mh_pkg::sts_t       sts,
	output logic [31:0]            digest_word
);

	logic [4:0][31:0] h_q;
	logic [31:0]      a_q, b_q, c_q, d_q, e_q;
	logic [511:0]     win_q;
	logic [63:0]      bit_count_q;
	logic [5:0]       pos_q;

	logic [7:0]  byte_d;
	logic [5:0]  len_shift;
	logic [31:0] w0, w2, w8, w13, w_new, t_sum;

	assign len_shift = {~cmd.len_idx, 3'b000};

	always_comb begin
		case (cmd.byte_sel)
			sha1mh_pkg::BSEL_IN:   byte_d = message_byte;
			sha1mh_pkg::BSEL_PAD:  byte_d = sha1mh_pkg::PAD_BYTE;
			sha1mh_pkg::BSEL_LEN:  byte_d = bit_count_q[len_shift +: 8];
			default:               byte_d = 8'h00;
		endcase
	end

	assign w0    = win_q[511:480];
	assign w2    = win_q[447:416];
	assign w8    = win_q[255:224];
	assign w13   = win_q[95:64];
	assign w_new = {w0[30:0] ^ w2[30:0] ^ w8[30:0] ^ w13[30:0],
	                w0[31] ^ w2[31] ^ w8[31] ^ w13[31]};

	assign t_sum = {a_q[26:0], a_q[31:27]}
	             + sha1mh_pkg::round_f(cmd.round_idx, b_q, c_q, d_q)
	             + e_q + sha1mh_pkg::round_k(cmd.round_idx) + w0;

	assign sts.pos_last   = (pos_q == sha1mh_pkg::LAST_POS);
	assign sts.pos_at_len = (pos_q == sha1mh_pkg::LEN_POS);

	always_comb begin
		case (cmd.out_idx)
			3'd0:    digest_word = h_q[0];
			3'd1:    digest_word = h_q[1];
			3'd2:    digest_word = h_q[2];
			3'd3:    digest_word = h_q[3];
			3'd4:    digest_word = h_q[4];
			default: digest_word = 32'h0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q         <= sha1mh_pkg::H_INIT;
			bit_count_q <= 64'd0;
			pos_q       <= 6'd0;
		end else if (cmd.reinit) begin
			h_q         <= sha1mh_pkg::H_INIT;
			bit_count_q <= 64'd0;
			pos_q       <= 6'd0;
		end else begin
			if (cmd.load_byte) begin
				pos_q <= pos_q + 6'd1;
			end
			if (cmd.count_byte) begin
				bit_count_q <= bit_count_q + 64'd8;
			end
			if (cmd.add_en) begin
				h_q[0] <= h_q[0] + a_q;
				h_q[1] <= h_q[1] + b_q;
				h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q;
				h_q[4] <= h_q[4] + e_q;
			end
		end
	end

	// window and round registers carry payload only
	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			win_q <= {win_q[503:0], byte_d};
		end else if (cmd.round_en) begin
			win_q <= {win_q[479:0], w_new};
		end
		if (cmd.round_start) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.round_en) begin
			a_q <= t_sum;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sha1mh_ctrl.sv =====
// sha-1 controller: byte intake, padding sequence, round count and digest output
`timescale 1ns / 1ps
`default_nettype none
module sha1mh_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              byte_present,
	input  wire logic              end_of_message,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [2:0]             word_index,
	output logic                   last_word,
	input  wire sha1mh_pkg::sts_t  sts,
	output sha1mh_pkg::cmd_t       cmd
);

	sha1mh_pkg::state_t state_q, state_d, ret_q;
	logic [6:0] round_q;
	logic [2:0] len_cnt_q;
	logic [2:0] out_idx_q;
	logic       pad_first_q;
	logic       len_phase_q;

	logic in_xfer;
	logic len_active;
	logic out_done;

	assign in_xfer    = in_valid && (state_q == sha1mh_pkg::S_IDLE);
	assign len_active = len_phase_q || (!pad_first_q && sts.pos_at_len);
	assign out_done   = out_ready && (out_idx_q == sha1mh_pkg::LAST_WORD);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sha1mh_pkg::S_IDLE: begin
				if (in_xfer) begin
					if (byte_present && sts.pos_last) begin
						state_d = sha1mh_pkg::S_COMP;
					end else if (end_of_message) begin
						state_d = sha1mh_pkg::S_PAD;
					end
				end
			end
			sha1mh_pkg::S_PAD: begin
				if (sts.pos_last) begin
					state_d = sha1mh_pkg::S_COMP;
				end
			end
			sha1mh_pkg::S_COMP: begin
				if (round_q == sha1mh_pkg::LAST_ROUND) begin
					state_d = sha1mh_pkg::S_ADD;
				end
			end
			sha1mh_pkg::S_ADD: begin
				state_d = ret_q;
			end
			sha1mh_pkg::S_OUT: begin
				if (out_done) begin
					state_d = sha1mh_pkg::S_IDLE;
				end
			end
			default: state_d = sha1mh_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		out_valid       = 1'b0;
		cmd             = '0;
		cmd.byte_sel    = sha1mh_pkg::BSEL_IN;
		cmd.len_idx     = len_cnt_q;
		cmd.round_idx   = round_q;
		cmd.out_idx     = out_idx_q;
		unique case (state_q)
			sha1mh_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_xfer && byte_present) begin
					cmd.load_byte   = 1'b1;
					cmd.count_byte  = 1'b1;
					cmd.round_start = sts.pos_last;
				end
			end
			sha1mh_pkg::S_PAD: begin
				cmd.load_byte   = 1'b1;
				cmd.round_start = sts.pos_last;
				if (pad_first_q) begin
					cmd.byte_sel = sha1mh_pkg::BSEL_PAD;
				end else if (len_active) begin
					cmd.byte_sel = sha1mh_pkg::BSEL_LEN;
				end else begin
					cmd.byte_sel = sha1mh_pkg::BSEL_ZERO;
				end
			end
			sha1mh_pkg::S_COMP: begin
				cmd.round_en = 1'b1;
			end
			sha1mh_pkg::S_ADD: begin
				cmd.add_en = 1'b1;
			end
			sha1mh_pkg::S_OUT: begin
				out_valid  = 1'b1;
				cmd.reinit = out_done;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign word_index = out_idx_q;
	assign last_word  = (out_idx_q == sha1mh_pkg::LAST_WORD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sha1mh_pkg::S_IDLE;
			ret_q       <= sha1mh_pkg::S_IDLE;
			round_q     <= 7'd0;
			len_cnt_q   <= 3'd0;
			out_idx_q   <= 3'd0;
			pad_first_q <= 1'b0;
			len_phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sha1mh_pkg::S_IDLE && in_xfer) begin
				if (byte_present && sts.pos_last) begin
					ret_q <= end_of_message ? sha1mh_pkg::S_PAD : sha1mh_pkg::S_IDLE;
				end
				if (end_of_message) begin
					pad_first_q <= 1'b1;
					len_phase_q <= 1'b0;
					len_cnt_q   <= 3'd0;
				end
			end
			if (state_q == sha1mh_pkg::S_PAD) begin
				pad_first_q <= 1'b0;
				if (len_active) begin
					len_phase_q <= 1'b1;
					len_cnt_q   <= len_cnt_q + 3'd1;
				end
				if (sts.pos_last) begin
					ret_q <= len_active ? sha1mh_pkg::S_OUT : sha1mh_pkg::S_PAD;
				end
			end
			if (cmd.round_start) begin
				round_q <= 7'd0;
			end else if (state_q == sha1mh_pkg::S_COMP) begin
				round_q <= round_q + 7'd1;
			end
			if (state_q == sha1mh_pkg::S_ADD) begin
				out_idx_q <= 3'd0;
			end else if (state_q == sha1mh_pkg::S_OUT && out_ready) begin
				out_idx_q <= out_idx_q + 3'd1;
			end
		end
	end

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sha1mh_pkg::S_COMP |-> round_q <= sha1mh_pkg::LAST_ROUND)
		else $error("round counter past last round");

	a_out_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_idx_q <= sha1mh_pkg::LAST_WORD)
		else $error("digest word index out of range");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while digest pending");

	a_add_return: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sha1mh_pkg::S_ADD |=> state_q == $past(ret_q))
		else $error("wrong state after block add");

	a_len_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sha1mh_pkg::S_ADD && ret_q == sha1mh_pkg::S_OUT |-> len_phase_q)
		else $error("digest output before length appended");

endmodule
`default_nettype wire

// ===== rtl/sha1_message_hasher_core.sv =====
// top level of the sha-1 message hasher: controller plus datapath
//
// channel   dir  handshake            payload
// input     in   in_valid/in_ready    byte_present, message_byte, end_of_message
// output    out  out_valid/out_ready  digest_word, word_index, last_word
//
// a full 64-byte block runs 80 rounds on the single round unit,
// followed by the chaining add
// an end mark appends 9 to 72 pad and length bytes and adds one or two blocks
// the digest leaves as five transfers, one per cycle when out_ready is high
// input is taken only in the idle state; a stalled output holds the digest word
// reset loads the initial chaining words and clears the bit count and byte position
`timescale 1ns / 1ps
`default_nettype none
module sha1_message_hasher_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        byte_present,
	input  wire logic [7:0]  message_byte,
	input  wire logic        end_of_message,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);

	sha1mh_pkg::cmd_t cmd;
	sha1mh_pkg::sts_t sts;

	sha1mh_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.word_index     (word_index),
		.last_word      (last_word),
		.sts            (sts),
		.cmd            (cmd)
	);

	sha1mh_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.message_byte (message_byte),
		.sts          (sts),
		.digest_word  (digest_word)
	);

endmodule
`default_nettype wire
